// ----- src/k_way_ordered_merge_assert.svh -----
// Assertion macros used by the merge block's datapath.
// Depends on nothing; files that assert include it by its bare name.
`ifndef K_WAY_ORDERED_MERGE_ASSERT_SVH
`define K_WAY_ORDERED_MERGE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KWM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kwm_pkg.sv -----
// Package of the k-way ordered merge: state encoding, command and status
// structs between controller and datapath, and fixed field widths.
package kwm_pkg;

    localparam int SRC_BITS  = 4;
    localparam int CFG_BITS  = 5;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    localparam logic CMD_HEAD    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_EMIT,
        S_POP_LOAD,
        S_DN,
        S_DN_SEL,
        S_DN_CMP
    } t_state;

    typedef struct packed {
        logic load;
        logic push;
        logic clear;
        logic up_read;
        logic up_shift;
        logic up_place;
        logic pop_read;
        logic pop_load;
        logic dn_read;
        logic dn_sel;
        logic dn_shift;
        logic dn_place;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic heap_full;
        logic pos_zero;
        logic l_in;
        logic r_in;
        logic new_lt_rd;
        logic r_lt_l;
        logic c_lt_m;
        logic out_free;
    } t_status;

endpackage

// ----- src/k_way_ordered_merge.sv -----
// Top level of the k-way ordered merge: a binary min-heap merge of sorted
// key streams. Depends on kwm_pkg, kwm_ctrl, kwm_dp (and through it kwm_ram).
//
//  Channel   Direction  Handshake               Carries
//  in        request    i_in_valid / o_in_stall command, stream_index, key, stream_ended
//  out       result     o_out_valid / i_out_stall out_key, out_stream, merge_done
//  cfg       write      i_cfg_valid / o_cfg_ready num_streams (5 bits)
//
// One request is taken at a time; a new one is accepted once the heap work of
// the previous one is finished, even while its result still waits at the output.
// A push climbs one level per step: read the parent, compare, and shift the parent
// down or place the entry. An emit reads the root and the last entry, loads the
// root into the result register, then sinks the last entry one level per step:
// read both children, select the smaller, compare, and shift it up or place the
// entry. The heap RAM gives one write and one pair of reads per cycle.
// Reset (synchronous, active low) empties the heap and restores sixteen streams;
// a restart request clears the heap when it is accepted and leaves the block idle.
// An output stall holds the result register and halts the block only when a new
// result is ready and the old one is not yet taken.
module k_way_ordered_merge
    import kwm_pkg::*;
#(
    parameter int MAX_STREAMS = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [SRC_BITS-1:0] i_stream_index,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_stream_ended,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KEY_BITS-1:0] o_out_key,
    output logic [SRC_BITS-1:0] o_out_stream,
    output logic                o_merge_done,
    // Configuration channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    // The controller sequences every request; the datapath owns the heap and
    // reports the comparisons and bounds the controller branches on.
    t_cmd    cmd;
    t_status status;

    kwm_ctrl #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_stream_ended (i_stream_ended),
        .o_in_stall     (o_in_stall),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // The datapath holds the output register, so a finished result waits there
    // while the next request is already being merged into the heap.
    kwm_dp #(
        .MAX_STREAMS (MAX_STREAMS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stream_index (i_stream_index),
        .i_key          (i_key),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_key      (o_out_key),
        .o_out_stream   (o_out_stream),
        .o_merge_done   (o_merge_done),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

// ----- src/kwm_ram.sv -----
// Generic simple dual-port RAM: one write port, two registered read ports.
// Depends on nothing.
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/kwm_ctrl.sv -----
// Controller of the k-way ordered merge: state machine, priming count and
// the stream-count register. Depends on kwm_pkg.
module kwm_ctrl
    import kwm_pkg::*;
#(
    parameter int MAX_STREAMS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    input  logic                i_stream_ended,
    output logic                o_in_stall,
    input  logic                i_cfg_valid,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output logic                o_cfg_ready,
    input  t_status             i_status,
    output t_cmd                o_cmd
);

    localparam int CW  = $clog2(MAX_STREAMS + 1);
    localparam int HCW = (CW > CFG_BITS) ? CW : CFG_BITS;

    t_state              r_state, n_state;
    logic [CFG_BITS-1:0] r_num_streams;
    logic [CW-1:0]       r_heads, n_heads;
    logic                r_priming, n_priming;
    logic                r_emit, n_emit;

    logic          w_accept;
    logic [CW-1:0] w_heads_inc;
    logic [HCW-1:0] w_cfg_ext;
    logic [HCW-1:0] w_max;
    logic [HCW-1:0] w_eff;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    // Effective stream count: zero acts as one, large values clamp.
    assign w_cfg_ext = HCW'(r_num_streams);
    assign w_max     = HCW'(MAX_STREAMS);
    assign w_eff     = (r_num_streams == '0) ? HCW'(1)
                     : ((w_cfg_ext > w_max) ? w_max : w_cfg_ext);
    assign w_heads_inc = (r_heads == CW'(MAX_STREAMS)) ? r_heads : r_heads + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_streams <= CFG_RESET;
            r_heads       <= '0;
            r_priming     <= 1'b0;
            r_emit        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_heads   <= n_heads;
            r_priming <= n_priming;
            r_emit    <= n_emit;
            if (i_cfg_valid) begin
                r_num_streams <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_heads   = r_heads;
        n_priming = r_priming;
        n_emit    = r_emit;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_RESTART) begin
                        o_cmd.clear = 1'b1;
                        n_heads     = '0;
                        n_priming   = 1'b0;
                    end else begin
                        o_cmd.load = 1'b1;
                        o_cmd.push = !i_stream_ended && !i_status.heap_full;
                        if (r_priming) begin
                            n_emit = 1'b1;
                        end else begin
                            n_heads = w_heads_inc;
                            if (HCW'(w_heads_inc) >= w_eff) begin
                                n_priming = 1'b1;
                                n_emit    = 1'b1;
                            end else begin
                                n_emit = 1'b0;
                            end
                        end
                        if (o_cmd.push) begin
                            n_state = S_UP;
                        end else if (n_emit) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_UP: begin
                if (i_status.pos_zero) begin
                    o_cmd.up_place = 1'b1;
                    n_state        = r_emit ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status.new_lt_rd) begin
                    o_cmd.up_shift = 1'b1;
                    n_state        = S_UP;
                end else begin
                    o_cmd.up_place = 1'b1;
                    n_state        = r_emit ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.count_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_done = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.pop_read = 1'b1;
                    n_state        = S_POP_LOAD;
                end
            end
            S_POP_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.pop_load = 1'b1;
                    n_state        = S_DN;
                end
            end
            S_DN: begin
                if (i_status.l_in) begin
                    o_cmd.dn_read = 1'b1;
                    n_state       = S_DN_SEL;
                end else begin
                    o_cmd.dn_place = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DN_SEL: begin
                o_cmd.dn_sel = 1'b1;
                n_state      = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_status.c_lt_m) begin
                    o_cmd.dn_shift = 1'b1;
                    n_state        = S_DN;
                end else begin
                    o_cmd.dn_place = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/kwm_dp.sv -----
// Datapath of the k-way ordered merge: heap RAM, entry registers, heap
// count, comparators and the output register. Depends on kwm_pkg, kwm_ram.
`include "k_way_ordered_merge_assert.svh"
module kwm_dp
    import kwm_pkg::*;
#(
    parameter int MAX_STREAMS = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SRC_BITS-1:0] i_stream_index,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [KEY_BITS-1:0] o_out_key,
    output logic [SRC_BITS-1:0] o_out_stream,
    output logic                o_merge_done,
    input  t_cmd                i_cmd,
    output t_status             o_status
);

    localparam int AW = $clog2(MAX_STREAMS);
    localparam int CW = $clog2(MAX_STREAMS + 1);
    localparam int EW = KEY_BITS + SRC_BITS;
    localparam int IW = AW + 2;

    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_pos;
    logic [EW-1:0]       r_new;
    logic [EW-1:0]       r_m;
    logic [EW-1:0]       r_child;
    logic [AW-1:0]       r_cidx;
    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [SRC_BITS-1:0] r_out_src;
    logic                r_out_done;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [EW-1:0] rd_a;
    logic [EW-1:0] rd_b;

    logic [AW-1:0] w_parent;
    logic [IW-1:0] w_left;
    logic [IW-1:0] w_right;
    logic [IW-1:0] w_count_ext;
    logic [CW-1:0] w_last;
    logic          w_out_free;

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_STREAMS)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Entries are {key, source}, so one unsigned compare orders by key and
    // then by the lower stream index.
    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_left      = {1'b0, r_pos, 1'b1};
    assign w_right     = w_left + IW'(1);
    assign w_count_ext = IW'(r_count);
    assign w_last      = r_count - CW'(1);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status            = '0;
        o_status.count_zero = (r_count == '0);
        o_status.heap_full  = (r_count == CW'(MAX_STREAMS));
        o_status.pos_zero   = (r_pos == '0);
        o_status.l_in       = (w_left < w_count_ext);
        o_status.r_in       = (w_right < w_count_ext);
        o_status.new_lt_rd  = (r_new < rd_a);
        o_status.r_lt_l     = (rd_b < rd_a);
        o_status.c_lt_m     = (r_child < r_m);
        o_status.out_free   = w_out_free;
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_new;
        ram_re      = 1'b0;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        if (i_cmd.up_read) begin
            ram_re      = 1'b1;
            ram_raddr_a = w_parent;
        end
        if (i_cmd.up_shift) begin
            ram_we    = 1'b1;
            ram_wdata = rd_a;
        end
        if (i_cmd.up_place) begin
            ram_we    = 1'b1;
            ram_wdata = r_new;
        end
        if (i_cmd.pop_read) begin
            ram_re      = 1'b1;
            ram_raddr_a = '0;
            ram_raddr_b = w_last[AW-1:0];
        end
        if (i_cmd.dn_read) begin
            ram_re      = 1'b1;
            ram_raddr_a = w_left[AW-1:0];
            ram_raddr_b = w_right[AW-1:0];
        end
        if (i_cmd.dn_shift) begin
            ram_we    = 1'b1;
            ram_wdata = r_child;
        end
        if (i_cmd.dn_place) begin
            ram_we    = 1'b1;
            ram_wdata = r_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_read) begin
                r_count <= w_last;
            end
            if (i_cmd.pop_load || i_cmd.emit_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new <= {i_key, i_stream_index};
        end
        if (i_cmd.push) begin
            r_pos <= r_count[AW-1:0];
        end else if (i_cmd.up_shift) begin
            r_pos <= w_parent;
        end else if (i_cmd.pop_load) begin
            r_pos <= '0;
        end else if (i_cmd.dn_shift) begin
            r_pos <= r_cidx;
        end
        if (i_cmd.pop_load) begin
            r_m       <= rd_b;
            r_out_key <= rd_a[EW-1:SRC_BITS];
            r_out_src <= rd_a[SRC_BITS-1:0];
            r_out_done <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_out_key  <= '0;
            r_out_src  <= '0;
            r_out_done <= 1'b1;
        end
        if (i_cmd.dn_sel) begin
            if (o_status.r_in && o_status.r_lt_l) begin
                r_child <= rd_b;
                r_cidx  <= w_right[AW-1:0];
            end else begin
                r_child <= rd_a;
                r_cidx  <= w_left[AW-1:0];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_stream = r_out_src;
    assign o_merge_done = r_out_done;

    `KWM_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_STREAMS), "heap count above capacity")
    `KWM_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop_read, r_count != '0, "pop from an empty heap")
    `KWM_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, i_cmd.pop_load || i_cmd.emit_done, w_out_free, "result overwrites a waiting result")
    `KWM_ASSERT_IMPLY(a_done_zero, i_clk, i_rst_n, r_out_valid && r_out_done, (r_out_key == '0) && (r_out_src == '0), "done result carries a key")
    `KWM_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, i_cmd.push, r_count == $past(r_count) + CW'(1), "push did not grow the heap")

endmodule

// ----- bench/tb_k_way_ordered_merge.sv -----
// Self-checking testbench for the k-way ordered merge: a heap predictor, directed tests
// and random merge sequences under sender idling and receiver stalls.
// Depends on kwm_pkg and k_way_ordered_merge only.
`timescale 1ns / 100ps

module tb_k_way_ordered_merge
    import kwm_pkg::*;
();

    localparam int KEY_W        = 64;
    localparam int HEAP_SLOTS   = 16;
    // Cycles allowed for heap work that ends in no result (restarts and
    // priming heads) to settle before the block counts as idle.
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SRC_BITS-1:0] stream;
        logic                done;
    } t_merge_out;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic                i_command      = CMD_HEAD;
    logic [SRC_BITS-1:0] i_stream_index = '0;
    logic [KEY_W-1:0]    i_key          = '0;
    logic                i_stream_ended = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [KEY_W-1:0]    o_out_key;
    logic [SRC_BITS-1:0] o_out_stream;
    logic                o_merge_done;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data     = '0;

    // Predictor state: the min-heap of (key, stream) entries and the priming
    // progress, plus the stream count last written to the block.
    logic [KEY_W-1:0]    heap_key [HEAP_SLOTS];
    logic [SRC_BITS-1:0] heap_src [HEAP_SLOTS];
    int                  heap_cnt     = 0;
    int                  heads_seen   = 0;
    bit                  primed       = 1'b0;
    logic [CFG_BITS-1:0] cfg_streams  = CFG_RESET;

    // Results predicted but not yet seen at the output, oldest first.
    t_merge_out          predicted_outputs[$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int sent_items = 0;
    int fail_count = 0;

    // Stream contents for the well-formed merge sequences.
    logic [KEY_W-1:0] stream_keys [HEAP_SLOTS][3];
    int               stream_len  [HEAP_SLOTS];
    int               stream_pos  [HEAP_SLOTS];

    k_way_ordered_merge u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_stream_index (i_stream_index),
        .i_key          (i_key),
        .i_stream_ended (i_stream_ended),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_key      (o_out_key),
        .o_out_stream   (o_out_stream),
        .o_merge_done   (o_merge_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------

    // Ordering of heap entries: smaller key first, the lower stream on a tie.
    function automatic bit entry_before(int a, int b);
        if (heap_key[a] != heap_key[b])
            return heap_key[a] < heap_key[b];
        return heap_src[a] < heap_src[b];
    endfunction

    function automatic void entry_exchange(int a, int b);
        logic [KEY_W-1:0]    k;
        logic [SRC_BITS-1:0] s;
        k = heap_key[a];
        s = heap_src[a];
        heap_key[a] = heap_key[b];
        heap_src[a] = heap_src[b];
        heap_key[b] = k;
        heap_src[b] = s;
    endfunction

    // Insert with a sift-up; an insert into a full heap is dropped.
    function automatic void heap_insert(logic [KEY_W-1:0] key, logic [SRC_BITS-1:0] src);
        int pos;
        int parent;
        if (heap_cnt >= HEAP_SLOTS)
            return;
        pos = heap_cnt;
        heap_key[pos] = key;
        heap_src[pos] = src;
        heap_cnt++;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!entry_before(pos, parent))
                break;
            entry_exchange(pos, parent);
            pos = parent;
        end
    endfunction

    // Removes the smallest entry with a sift-down, or reports done when the
    // heap is empty.
    function automatic t_merge_out heap_take();
        t_merge_out r;
        int         pos;
        int         lt;
        int         rt;
        int         best;
        r = '0;
        if (heap_cnt == 0) begin
            r.done = 1'b1;
            return r;
        end
        r.key    = heap_key[0];
        r.stream = heap_src[0];
        heap_cnt--;
        heap_key[0] = heap_key[heap_cnt];
        heap_src[0] = heap_src[heap_cnt];
        pos = 0;
        forever begin
            lt   = 2 * pos + 1;
            rt   = lt + 1;
            best = pos;
            if (lt < heap_cnt && entry_before(lt, best))
                best = lt;
            if (rt < heap_cnt && entry_before(rt, best))
                best = rt;
            if (best == pos)
                break;
            entry_exchange(pos, best);
            pos = best;
        end
        return r;
    endfunction

    // A register value of zero acts as one stream, values above the heap
    // size act as the heap size.
    function automatic int active_streams();
        if (cfg_streams == 0)
            return 1;
        if (cfg_streams > HEAP_SLOTS)
            return HEAP_SLOTS;
        return cfg_streams;
    endfunction

    // Applies one request to the predictor and queues the result, if any.
    task automatic merge_model_step(input logic cmd, input logic [SRC_BITS-1:0] src,
                                    input logic [KEY_W-1:0] key, input logic ended,
                                    output bit produced, output t_merge_out r);
        produced = 1'b0;
        r        = '0;
        if (cmd == CMD_RESTART) begin
            heap_cnt   = 0;
            heads_seen = 0;
            primed     = 1'b0;
            return;
        end
        if (!ended)
            heap_insert(key, src);
        if (!primed) begin
            if (heads_seen < HEAP_SLOTS)
                heads_seen++;
            if (heads_seen < active_streams())
                return;
            primed = 1'b1;
        end
        r        = heap_take();
        produced = 1'b1;
        predicted_outputs = {predicted_outputs, r};
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Presents one request, predicts its outcome and waits for acceptance.
    // Valid stays high afterwards so that back-to-back requests need no gap.
    task automatic send_request(input logic cmd, input logic [SRC_BITS-1:0] src,
                                input logic [KEY_W-1:0] key, input logic ended,
                                output bit produced, output t_merge_out r);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_stream_index <= src;
        i_key          <= key;
        i_stream_ended <= ended;
        merge_model_step(cmd, src, key, ended, produced, r);
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent_items++;
    endtask

    // Holds the sender back until every predicted result has been taken,
    // then gives any result-free heap work time to finish.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
    endtask

    // The stream count is only ever changed with the block idle.
    task automatic write_stream_count(input logic [CFG_BITS-1:0] value);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_streams = value;
    endtask

    // Takes a result whenever valid is high and no stall was driven, checks
    // it against the oldest prediction, and draws the next stall.
    always @(posedge i_clk) begin : result_check
        t_merge_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_outputs.size() == 0) begin
                    $error("unexpected result: out_key %h out_stream %0d merge_done %0b",
                           o_out_key, o_out_stream, o_merge_done);
                    fail_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (o_out_key !== want.key) begin
                        $error("out_key: expected %h, got %h", want.key, o_out_key);
                        fail_count++;
                    end
                    if (o_out_stream !== want.stream) begin
                        $error("out_stream: expected %0d, got %0d", want.stream, o_out_stream);
                        fail_count++;
                    end
                    if (o_merge_done !== want.done) begin
                        $error("merge_done: expected %0b, got %0b", want.done, o_merge_done);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Priming with the reset stream count of sixteen: the key extremes, ties
    // on key broken by stream, and ended streams whose key must be ignored.
    task automatic test_reset_value();
        bit         produced;
        t_merge_out r;
        int         s;
        for (s = HEAP_SLOTS - 1; s >= 8; s--)
            send_request(CMD_HEAD, SRC_BITS'(s), 64'd100 + s, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd7, '1, 1'b1, produced, r);
        send_request(CMD_HEAD, 4'd6, 64'd0, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd5, 64'd0, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd4, 64'd7, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd3, 64'd7, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd2, 64'd0, 1'b1, produced, r);
        send_request(CMD_HEAD, 4'd1, 64'h8000_0000_0000_0000, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd0, '1, 1'b0, produced, r);
        // Replacement for stream five, which holds the smallest key.
        send_request(CMD_HEAD, 4'd5, '1, 1'b0, produced, r);
        send_request(CMD_RESTART, 4'd0, 64'd0, 1'b0, produced, r);
    endtask

    // A register value of zero behaves as one stream: each head is emitted at
    // once, an end mark gives done, and requests after done are merged again.
    task automatic test_single_stream();
        bit         produced;
        t_merge_out r;
        write_stream_count(5'd0);
        send_request(CMD_HEAD, 4'd9, 64'd42, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd9, 64'd0, 1'b1, produced, r);
        send_request(CMD_HEAD, 4'd3, 64'd5, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd3, '1, 1'b1, produced, r);
        send_request(CMD_RESTART, 4'd15, '1, 1'b1, produced, r);
    endtask

    // An oversized register value, a duplicate head, a count lowered part way
    // through priming, and a replacement from a stream other than the emitted one.
    task automatic test_priming_edge();
        bit         produced;
        t_merge_out r;
        write_stream_count(5'd31);
        send_request(CMD_HEAD, 4'd0, 64'd10, 1'b0, produced, r);
        send_request(CMD_HEAD, 4'd0, 64'd3, 1'b0, produced, r);
        write_stream_count(5'd2);
        send_request(CMD_HEAD, 4'd1, 64'd0, 1'b1, produced, r);
        send_request(CMD_HEAD, 4'd12, 64'd1, 1'b0, produced, r);
        send_request(CMD_RESTART, 4'd0, 64'd0, 1'b0, produced, r);
    endtask

    // Next request of a stream in a merge sequence: its next key, or the end mark.
    task automatic next_item_of(input int src, output logic [KEY_W-1:0] key,
                                output logic ended);
        if (stream_pos[src] < stream_len[src]) begin
            key   = stream_keys[src][stream_pos[src]];
            ended = 1'b0;
            stream_pos[src]++;
        end else begin
            key   = {$urandom, $urandom};
            ended = 1'b1;
        end
    endtask

    // One well-formed merge: restart, one head per stream in shuffled order,
    // then the replacement for each emitted stream until done.
    task automatic run_merge_sequence();
        int               n;
        int               i;
        int               j;
        int               tmp;
        int               mode;
        int               order[HEAP_SLOTS];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] nk;
        logic             ended;
        bit               produced;
        t_merge_out       r;
        send_request(CMD_RESTART, SRC_BITS'($urandom_range(15, 0)), {$urandom, $urandom},
                     1'($urandom_range(1, 0)), produced, r);
        n = active_streams();
        // Narrow keys give many ties across streams; the top range reaches
        // the largest key.
        for (i = 0; i < HEAP_SLOTS; i++) begin
            stream_len[i] = $urandom_range(3, 0);
            stream_pos[i] = 0;
            mode = $urandom_range(2, 0);
            case (mode)
                0:       k = $urandom_range(15, 0);
                1:       k = {$urandom, $urandom} >> $urandom_range(8, 0);
                default: k = '1 - $urandom_range(20, 0);
            endcase
            for (j = 0; j < stream_len[i]; j++) begin
                stream_keys[i][j] = k;
                case (mode)
                    0:       nk = k + $urandom_range(3, 0);
                    1:       nk = k + $urandom;
                    default: nk = k + $urandom_range(2, 0);
                endcase
                k = (nk < k) ? '1 : nk;
            end
        end
        for (i = 0; i < n; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++) begin
            next_item_of(order[i], k, ended);
            send_request(CMD_HEAD, SRC_BITS'(order[i]), k, ended, produced, r);
        end
        while (produced && !r.done) begin
            next_item_of(r.stream, k, ended);
            send_request(CMD_HEAD, r.stream, k, ended, produced, r);
        end
        // Now and then a request after done, which is merged once more.
        if ($urandom_range(3, 0) == 0)
            send_request(CMD_HEAD, SRC_BITS'($urandom_range(15, 0)), {$urandom, $urandom},
                         1'b0, produced, r);
    endtask

    // A short burst of unordered requests with random fields and restarts.
    task automatic run_noise_burst();
        int               i;
        int               count;
        logic [KEY_W-1:0] k;
        bit               produced;
        t_merge_out       r;
        count = $urandom_range(6, 1);
        for (i = 0; i < count; i++) begin
            case ($urandom_range(3, 0))
                0:       k = '0;
                1:       k = '1;
                default: k = {$urandom, $urandom};
            endcase
            send_request(($urandom_range(9, 0) == 0) ? CMD_RESTART : CMD_HEAD,
                         SRC_BITS'($urandom_range(15, 0)), k, ($urandom_range(3, 0) == 0),
                         produced, r);
        end
    endtask

    // Random phase: mostly merge sequences, some noise, and stream count
    // changes with the block drained in between.
    task automatic test_random_merge(input int idle, input int stall, input int items,
                                     input logic [CFG_BITS-1:0] first_count);
        int stop_at;
        int choice;
        int pick;
        write_stream_count(first_count);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = sent_items + items;
        while (sent_items < stop_at) begin
            choice = $urandom_range(99, 0);
            if (choice < 12) begin
                run_noise_burst();
            end else if (choice < 22) begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    write_stream_count(CFG_BITS'($urandom_range(16, 1)));
                else if (pick < 85)
                    write_stream_count(5'd0);
                else
                    write_stream_count(CFG_BITS'($urandom_range(31, 17)));
            end else begin
                run_merge_sequence();
            end
        end
    endtask

    initial begin
        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_single_stream();
        test_priming_edge();
        test_random_merge(0, 0, 100, 5'd16);
        test_random_merge(47, 0, 100, 5'd1);
        test_random_merge(0, 47, 100, 5'd5);
        test_random_merge(25, 25, 100, 5'd31);

        drain_block();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
